@@ src/mrte_pkg.sv @@
// Shared types and codes of the mesh route table engine.
// No dependencies; imported by mrte_scan, mesh_route_table_engine and both test files.
package mrte_pkg;

  typedef enum logic [1:0] {
    OP_RX   = 2'd0,
    OP_SEND = 2'd1,
    OP_TICK = 2'd2,
    OP_NONE = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    CFG_NODE_ID  = 2'd0,
    CFG_MAX_HOPS = 2'd1,
    CFG_TIMEOUT  = 2'd2,
    CFG_BEACON   = 2'd3
  } cfg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_TAIL,
    ST_WRITE,
    ST_DONE
  } state_t;

  localparam logic [2:0] KIND_RREQ   = 3'd1;
  localparam logic [2:0] KIND_BEACON = 3'd4;

  localparam logic [7:0] ADDR_BCAST = 8'hFF;
  localparam logic [7:0] ADDR_NONE  = 8'h00;
  localparam logic [7:0] BEACON_TTL = 8'd1;
  localparam logic [7:0] DIRECT_HOP = 8'd1;

  // one route table entry; the valid mark lives in flops beside the RAM
  typedef struct packed {
    logic [7:0]  dst;
    logic [7:0]  via;
    logic [7:0]  hops;
    logic [31:0] stamp;
  } route_t;

  // scan results handed from the scan unit to the controller
  typedef struct packed {
    logic hit;
    logic free_found;
  } scan_flags_t;

endpackage

@@ src/mrte_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
module mrte_ram #(
  parameter int WIDTH = 56,
  parameter int DEPTH = 16
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic                                    re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ src/mrte_scan.sv @@
// Scan unit: looks at one table entry per cycle and keeps the first match,
// the first free slot and the oldest slot. Depends on mrte_pkg.
module mrte_scan #(
  parameter int IDX_W = 4
) (
  input  logic                 clk,
  input  logic                 clear,
  input  logic                 pend,
  input  logic [IDX_W-1:0]     idx,
  input  mrte_pkg::route_t     ent,
  input  logic                 ent_valid,
  input  logic [7:0]           key,
  input  logic [31:0]          now,
  input  logic [31:0]          timeout,
  output mrte_pkg::scan_flags_t flags,
  output logic [IDX_W-1:0]     hit_idx,
  output logic [7:0]           hit_via,
  output logic [IDX_W-1:0]     free_idx,
  output logic [IDX_W-1:0]     old_idx,
  output logic                 stale
);
  import mrte_pkg::*;

  scan_flags_t      flags_r;
  logic [IDX_W-1:0] hit_idx_r, free_idx_r, old_idx_r;
  logic [7:0]       hit_via_r;
  logic [31:0]      old_age_r;
  logic [31:0]      age;

  assign age   = now - ent.stamp;
  assign stale = pend && ent_valid && (age > timeout);

  always_ff @(posedge clk) begin
    if (clear) begin
      flags_r <= '0;
    end else if (pend) begin
      if (!flags_r.hit && ent_valid && ent.dst == key) begin
        flags_r.hit <= 1'b1;
        hit_idx_r   <= idx;
        hit_via_r   <= ent.via;
      end
      if (!flags_r.free_found && !ent_valid) begin
        flags_r.free_found <= 1'b1;
        free_idx_r         <= idx;
      end
      // strict compare keeps the lowest index on a tie
      if (idx == '0 || age > old_age_r) begin
        old_age_r <= age;
        old_idx_r <= idx;
      end
    end
  end

  assign flags    = flags_r;
  assign hit_idx  = hit_idx_r;
  assign hit_via  = hit_via_r;
  assign free_idx = free_idx_r;
  assign old_idx  = old_idx_r;

endmodule

@@ src/mesh_route_table_engine.sv @@
// Mesh route table engine: top level with control sequencer and registers.
// Depends on mrte_pkg, mrte_ram and mrte_scan.
//
// Usage:
//   Input channel (in_*): one item per handshake (valid high, stall low).
//   opcode 0 is a received header, 1 a send request, 2 a tick.
//   Output channel (out_*): exactly one result item per input item, in order.
//   Config port (cfg_*): write-only, one register per cycle with cfg_we;
//   write only while the block is idle.
// Timing:
//   Items that touch the table sweep all ROUTE_ENTRIES entries through the
//   one read port of the table RAM, one entry per cycle. A send request or
//   tick goes through the scan, tail and done states; a header that learns
//   a route adds the write state for the write back. Headers that learn
//   nothing and opcode 3 skip the sweep. The next item is accepted the
//   cycle after the result is loaded into the output register.
// Reset:
//   Synchronous, active low. Every table entry becomes invalid at once
//   (valid flags in flops), counters clear, registers take their defaults.
// Stall:
//   The result waits in the output register; a finished item holds in the
//   done state until the output register frees up.
module mesh_route_table_engine #(
  parameter int ROUTE_ENTRIES = 16,
  parameter int HEADER_BYTES  = 9
) (
  input  logic        clk,
  input  logic        rst_n,
  // configuration
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data,
  // input items
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_opcode,
  input  logic [31:0] in_now_ms,
  input  logic [2:0]  in_packet_kind,
  input  logic [7:0]  in_source_id,
  input  logic [7:0]  in_dest_id,
  input  logic [7:0]  in_prev_hop,
  input  logic [7:0]  in_hop_count,
  input  logic [7:0]  in_frame_length,
  // result items
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_delivered,
  output logic [7:0]  out_payload_length,
  output logic        out_emit_frame,
  output logic [7:0]  out_forward_id,
  output logic [7:0]  out_frame_ttl,
  output logic [15:0] out_sequence_number
);
  import mrte_pkg::*;

  localparam int IDX_W = (ROUTE_ENTRIES > 1) ? $clog2(ROUTE_ENTRIES) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ROUTE_ENTRIES - 1);
  localparam logic [7:0] HDR_LEN = 8'(HEADER_BYTES);

  // config registers
  logic [7:0]  node_id_r, max_hops_r;
  logic [31:0] timeout_r, beacon_int_r;

  // held item
  op_t         op_r;
  logic [31:0] now_r;
  logic [2:0]  kind_r;
  logic [7:0]  src_r, dst_r, prev_r, hops_r, flen_r;

  // control
  state_t            state_r, state_nxt;
  logic [IDX_W-1:0]  idx_r, idx_nxt;
  logic [IDX_W-1:0]  idx_d_r;
  logic              pend_r, pend_nxt;
  logic [ROUTE_ENTRIES-1:0] valid_r;
  logic [15:0]       seq_cnt_r;
  logic [31:0]       last_beacon_r;

  // output register
  logic        out_valid_r;
  logic        dlv_r, emit_r;
  logic [7:0]  plen_r, nh_r, ttl_r;
  logic [15:0] seq_r;

  logic in_accept, out_take, load_out;

  // RAM and scan hookup
  logic             ram_re, ram_we;
  logic [IDX_W-1:0] wr_slot;
  route_t           ram_rdata, ram_wdata;
  scan_flags_t      sflags;
  logic [IDX_W-1:0] hit_idx, free_idx, old_idx;
  logic [7:0]       hit_via, scan_key;
  logic             stale;

  // header decode
  logic       drop, relayed, is_beacon, learn_en, take, beacon_due, needs_scan;
  logic [7:0] l_via, l_hops;

  assign in_accept = in_valid && !in_stall;
  assign out_take  = out_valid_r && !out_stall;
  assign in_stall  = (state_r != ST_IDLE);

  assign drop      = (flen_r < HDR_LEN) || (hops_r >= max_hops_r);
  assign relayed   = (prev_r != ADDR_NONE) && (prev_r != ADDR_BCAST);
  assign is_beacon = (kind_r == KIND_BEACON);
  // for a relayed beacon the beacon values win over the relayed-header values in the one write
  assign learn_en  = (op_r == OP_RX) && !drop && (relayed || is_beacon);
  assign l_via     = is_beacon ? src_r : prev_r;
  assign l_hops    = is_beacon ? DIRECT_HOP : hops_r;
  assign take      = !drop && !is_beacon &&
                     ((dst_r == node_id_r) ||
                      (kind_r != KIND_RREQ && dst_r == ADDR_BCAST));
  assign beacon_due = (now_r - last_beacon_r) >= beacon_int_r;
  assign needs_scan = (op_r == OP_SEND) || (op_r == OP_TICK) || learn_en;
  assign scan_key   = (op_r == OP_SEND) ? dst_r : src_r;

  assign wr_slot = sflags.hit        ? hit_idx :
                   sflags.free_found ? free_idx : old_idx;
  assign ram_wdata = '{dst: src_r, via: l_via, hops: l_hops, stamp: now_r};

  mrte_ram #(
    .WIDTH ($bits(route_t)),
    .DEPTH (ROUTE_ENTRIES)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wr_slot),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (idx_r),
    .rdata (ram_rdata)
  );

  mrte_scan #(
    .IDX_W (IDX_W)
  ) u_scan (
    .clk       (clk),
    .clear     (in_accept),
    .pend      (pend_r),
    .idx       (idx_d_r),
    .ent       (ram_rdata),
    .ent_valid (valid_r[idx_d_r]),
    .key       (scan_key),
    .now       (now_r),
    .timeout   (timeout_r),
    .flags     (sflags),
    .hit_idx   (hit_idx),
    .hit_via   (hit_via),
    .free_idx  (free_idx),
    .old_idx   (old_idx),
    .stale     (stale)
  );

  // sequencer: one item at a time, so table accesses never overlap
  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    pend_nxt  = 1'b0;
    ram_re    = 1'b0;
    ram_we    = 1'b0;
    load_out  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        idx_nxt = '0;
        if (in_accept) begin
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (!needs_scan) begin
          state_nxt = ST_DONE;
        end else begin
          ram_re   = 1'b1;
          pend_nxt = 1'b1;
          if (idx_r == LAST_IDX) begin
            state_nxt = ST_TAIL;
          end else begin
            idx_nxt = idx_r + 1'b1;
          end
        end
      end
      ST_TAIL: begin
        state_nxt = learn_en ? ST_WRITE : ST_DONE;
      end
      ST_WRITE: begin
        ram_we    = 1'b1;
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_r || !out_stall) begin
          load_out  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      pend_r  <= 1'b0;
      idx_r   <= '0;
    end else begin
      state_r <= state_nxt;
      pend_r  <= pend_nxt;
      idx_r   <= idx_nxt;
    end
    idx_d_r <= idx_r;
  end

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      node_id_r    <= 8'd1;
      max_hops_r   <= 8'd8;
      timeout_r    <= 32'd120000;
      beacon_int_r <= 32'd30000;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_NODE_ID:  node_id_r    <= cfg_data[7:0];
        CFG_MAX_HOPS: max_hops_r   <= cfg_data[7:0];
        CFG_TIMEOUT:  timeout_r    <= cfg_data;
        CFG_BEACON:   beacon_int_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // item capture
  always_ff @(posedge clk) begin
    if (in_accept) begin
      op_r   <= op_t'(in_opcode);
      now_r  <= in_now_ms;
      kind_r <= in_packet_kind;
      src_r  <= in_source_id;
      dst_r  <= in_dest_id;
      prev_r <= in_prev_hop;
      hops_r <= in_hop_count;
      flen_r <= in_frame_length;
    end
  end

  // valid flags: tick clears stale entries as they stream past, learn sets
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (ram_we) begin
      valid_r[wr_slot] <= 1'b1;
    end else if (stale && op_r == OP_TICK) begin
      valid_r[idx_d_r] <= 1'b0;
    end
  end

  // sequence counter, beacon timer and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seq_cnt_r     <= '0;
      last_beacon_r <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      if (load_out) begin
        out_valid_r <= 1'b1;
        dlv_r  <= 1'b0;
        plen_r <= '0;
        emit_r <= 1'b0;
        nh_r   <= '0;
        ttl_r  <= '0;
        seq_r  <= '0;
        case (op_r)
          OP_RX: begin
            if (take) begin
              dlv_r  <= 1'b1;
              plen_r <= flen_r - HDR_LEN;
            end
          end
          OP_SEND: begin
            emit_r    <= 1'b1;
            nh_r      <= (dst_r != ADDR_BCAST && sflags.hit) ? hit_via : ADDR_BCAST;
            ttl_r     <= max_hops_r;
            seq_r     <= seq_cnt_r;
            seq_cnt_r <= seq_cnt_r + 16'd1;
          end
          OP_TICK: begin
            if (beacon_due) begin
              last_beacon_r <= now_r;
              emit_r        <= 1'b1;
              nh_r          <= ADDR_BCAST;
              ttl_r         <= BEACON_TTL;
              seq_r         <= seq_cnt_r;
              seq_cnt_r     <= seq_cnt_r + 16'd1;
            end
          end
          default: ;
        endcase
      end else if (out_take) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid           = out_valid_r;
  assign out_delivered       = dlv_r;
  assign out_payload_length  = plen_r;
  assign out_emit_frame      = emit_r;
  assign out_forward_id      = nh_r;
  assign out_frame_ttl       = ttl_r;
  assign out_sequence_number = seq_r;

`ifndef ASSERT_OFF
  // a result shows up only after the sequencer finished an item
  a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_DONE))
    else $error("result without finished item");

  // the sequence counter only ever steps by one
  a_seq_step: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && seq_cnt_r != $past(seq_cnt_r)) |->
      (seq_cnt_r == $past(seq_cnt_r) + 16'd1))
    else $error("sequence counter jumped");

  // at most one route is learned per cycle
  a_one_learn: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> ($countones(valid_r) <= $countones($past(valid_r)) + 1))
    else $error("more than one route learned at once");
`endif

endmodule

@@ test/mrte_route_checker.sv @@
// Route table checker: watches the config port and both item channels,
// predicts each result from its own copy of the table and compares.
// Depends on mrte_pkg for the opcode, register index and route entry types.
module mrte_route_checker #(
  parameter int ROUTE_ENTRIES = 16,
  parameter int HEADER_BYTES  = 9
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [1:0]  in_opcode,
  input  logic [31:0] in_now_ms,
  input  logic [2:0]  in_packet_kind,
  input  logic [7:0]  in_source_id,
  input  logic [7:0]  in_dest_id,
  input  logic [7:0]  in_prev_hop,
  input  logic [7:0]  in_hop_count,
  input  logic [7:0]  in_frame_length,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic        out_delivered,
  input  logic [7:0]  out_payload_length,
  input  logic        out_emit_frame,
  input  logic [7:0]  out_forward_id,
  input  logic [7:0]  out_frame_ttl,
  input  logic [15:0] out_sequence_number,
  output int          fail_count,
  output int          pending
);
  import mrte_pkg::*;

  typedef struct packed {
    logic        delivered;
    logic [7:0]  payload_length;
    logic        emit_frame;
    logic [7:0]  forward_id;
    logic [7:0]  frame_ttl;
    logic [15:0] sequence_number;
  } route_result_t;

  route_t        route_mem  [ROUTE_ENTRIES];
  logic          route_live [ROUTE_ENTRIES];
  logic [15:0]   seq_ctr;
  logic [31:0]   last_beacon_ms;
  logic [7:0]    node_id_r;
  logic [7:0]    max_hops_r;
  logic [31:0]   timeout_r;
  logic [31:0]   beacon_r;
  route_result_t expected_results [$];

  initial begin
    fail_count = 0;
    pending    = 0;
  end

  function automatic int find_route(input logic [7:0] dst);
    for (int i = 0; i < ROUTE_ENTRIES; i++)
      if (route_live[i] && route_mem[i].dst == dst) return i;
    return -1;
  endfunction

  // free slot first, else the oldest entry (lowest index on a tie)
  function automatic int victim_slot(input logic [31:0] now);
    int          best;
    logic [31:0] best_age;
    logic [31:0] age;
    for (int i = 0; i < ROUTE_ENTRIES; i++)
      if (!route_live[i]) return i;
    best     = 0;
    best_age = now - route_mem[0].stamp;
    for (int i = 1; i < ROUTE_ENTRIES; i++) begin
      age = now - route_mem[i].stamp;
      if (age > best_age) begin
        best_age = age;
        best     = i;
      end
    end
    return best;
  endfunction

  task automatic learn_route(input logic [7:0] dst, input logic [7:0] via,
                             input logic [7:0] hops, input logic [31:0] now);
    int k;
    k = find_route(dst);
    if (k < 0) k = victim_slot(now);
    route_mem[k].dst   = dst;
    route_mem[k].via   = via;
    route_mem[k].hops  = hops;
    route_mem[k].stamp = now;
    route_live[k]      = 1'b1;
  endtask

  task automatic predict_route_result(
    input op_t op, input logic [31:0] now, input logic [2:0] kind,
    input logic [7:0] src, input logic [7:0] dst, input logic [7:0] prev,
    input logic [7:0] hops, input logic [7:0] flen);
    route_result_t r;
    logic          take;
    int            k;
    logic [31:0]   age;
    r = '0;
    case (op)
      OP_RX: begin
        if (flen >= HEADER_BYTES && hops < max_hops_r) begin
          if (prev != ADDR_NONE && prev != ADDR_BCAST) learn_route(src, prev, hops, now);
          if (kind == KIND_BEACON) begin
            learn_route(src, src, DIRECT_HOP, now);
            take = 1'b0;
          end else if (kind == KIND_RREQ) begin
            take = (dst == node_id_r);
          end else begin
            take = (dst == node_id_r) || (dst == ADDR_BCAST);
          end
          if (take) begin
            r.delivered      = 1'b1;
            r.payload_length = 8'(flen - HEADER_BYTES);
          end
        end
      end
      OP_SEND: begin
        r.emit_frame = 1'b1;
        if (dst == ADDR_BCAST) begin
          r.forward_id = ADDR_BCAST;
        end else begin
          k            = find_route(dst);
          r.forward_id = (k >= 0) ? route_mem[k].via : ADDR_BCAST;
        end
        r.frame_ttl       = max_hops_r;
        r.sequence_number = seq_ctr;
        seq_ctr           = seq_ctr + 16'd1;
      end
      OP_TICK: begin
        // expiry runs before the beacon decision
        for (int i = 0; i < ROUTE_ENTRIES; i++) begin
          age = now - route_mem[i].stamp;
          if (route_live[i] && age > timeout_r) route_live[i] = 1'b0;
        end
        age = now - last_beacon_ms;
        if (age >= beacon_r) begin
          last_beacon_ms    = now;
          r.emit_frame      = 1'b1;
          r.forward_id      = ADDR_BCAST;
          r.frame_ttl       = BEACON_TTL;
          r.sequence_number = seq_ctr;
          seq_ctr           = seq_ctr + 16'd1;
        end
      end
      default: ;
    endcase
    expected_results.push_back(r);
  endtask

  function automatic int field_differs(input string name, input logic [31:0] exp_v,
                                       input logic [31:0] act_v);
    if (act_v !== exp_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
      return 1;
    end
    return 0;
  endfunction

  always @(posedge clk) begin : monitor
    route_result_t exp_r;
    int            errs;
    if (!rst_n) begin
      for (int i = 0; i < ROUTE_ENTRIES; i++) begin
        route_mem[i]  = '0;
        route_live[i] = 1'b0;
      end
      seq_ctr        = '0;
      last_beacon_ms = '0;
      node_id_r      = 8'd1;
      max_hops_r     = 8'd8;
      timeout_r      = 32'd120000;
      beacon_r       = 32'd30000;
      expected_results.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_idx_t'(cfg_index))
          CFG_NODE_ID:  node_id_r  = cfg_data[7:0];
          CFG_MAX_HOPS: max_hops_r = cfg_data[7:0];
          CFG_TIMEOUT:  timeout_r  = cfg_data;
          CFG_BEACON:   beacon_r   = cfg_data;
          default: ;
        endcase
      end
      // a result seen here always belongs to an item accepted earlier
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          $error("result item with no expectation waiting");
          fail_count++;
        end else begin
          exp_r = expected_results.pop_front();
          errs  = field_differs("delivered", 32'(exp_r.delivered), 32'(out_delivered))
                + field_differs("payload_length", 32'(exp_r.payload_length),
                                32'(out_payload_length))
                + field_differs("emit_frame", 32'(exp_r.emit_frame), 32'(out_emit_frame))
                + field_differs("forward_id", 32'(exp_r.forward_id), 32'(out_forward_id))
                + field_differs("frame_ttl", 32'(exp_r.frame_ttl), 32'(out_frame_ttl))
                + field_differs("sequence_number", 32'(exp_r.sequence_number),
                                32'(out_sequence_number));
          fail_count += errs;
        end
      end
      if (in_valid && !in_stall)
        predict_route_result(op_t'(in_opcode), in_now_ms, in_packet_kind, in_source_id,
                             in_dest_id, in_prev_hop, in_hop_count, in_frame_length);
    end
    pending = expected_results.size();
  end

endmodule

@@ test/mesh_route_table_engine_tb.sv @@
// Testbench top for the mesh route table engine: clock, reset, stimulus
// and verdict; results are checked by mrte_route_checker.
// Depends on mrte_pkg, mesh_route_table_engine and mrte_route_checker.
module mesh_route_table_engine_tb;
  import mrte_pkg::*;

  localparam int ROUTE_ENTRIES = 16;
  localparam int HEADER_BYTES  = 9;
  localparam int HOLD_CYCLES   = 300;   // long receiver hold-off
  localparam int PHASE_ITEMS   = 240;

  // packet kinds without a name in the package
  localparam logic [2:0] KIND_DATA = 3'd0;
  localparam logic [2:0] KIND_RREP = 3'd2;
  localparam logic [2:0] KIND_RERR = 3'd3;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [31:0] cfg_data;
  logic        in_valid;
  logic        in_stall;
  logic [1:0]  in_opcode;
  logic [31:0] in_now_ms;
  logic [2:0]  in_packet_kind;
  logic [7:0]  in_source_id;
  logic [7:0]  in_dest_id;
  logic [7:0]  in_prev_hop;
  logic [7:0]  in_hop_count;
  logic [7:0]  in_frame_length;
  logic        out_valid;
  logic        out_stall;
  logic        out_delivered;
  logic [7:0]  out_payload_length;
  logic        out_emit_frame;
  logic [7:0]  out_forward_id;
  logic [7:0]  out_frame_ttl;
  logic [15:0] out_sequence_number;
  int          fail_count;
  int          pending;

  // stimulus-side view of the settings, used to shape items, and counts for the final report
  int          idle_pct;
  bit          hold_req;
  logic [31:0] clock_ms;
  logic [31:0] step_ms;
  logic [7:0]  cur_node;
  logic [7:0]  cur_maxh;
  int          items_sent;
  int          settings_used;

  mesh_route_table_engine #(
    .ROUTE_ENTRIES(ROUTE_ENTRIES),
    .HEADER_BYTES (HEADER_BYTES)
  ) u_dut (.*);

  mrte_route_checker #(
    .ROUTE_ENTRIES(ROUTE_ENTRIES),
    .HEADER_BYTES (HEADER_BYTES)
  ) u_checker (.*);

  always begin
    clk = 1'b1;
    #1;
    clk = 1'b0;
    #1;
  end

  // hard stop: far beyond the slowest legal run
  initial begin
    #2000000;
    $display("Mismatches found");
    $finish;
  end

  // Receiver: random stalls, plus one long hold-off on request. The
  // hold-off is counted here, apart from the sender, which keeps its item offered meanwhile.
  initial begin
    bit hold_done;
    hold_done = 1'b0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        out_stall = 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      out_stall = ($urandom_range(0, 99) < idle_pct);
    end
  end

  // One item: optional idle gap, then hold the payload until accepted.
  task automatic send_item(input op_t op, input logic [31:0] now, input logic [2:0] kind,
                           input logic [7:0] src, input logic [7:0] dst,
                           input logic [7:0] prev, input logic [7:0] hops,
                           input logic [7:0] flen);
    while ($urandom_range(0, 99) < idle_pct) begin
      @(negedge clk);
      in_valid = 1'b0;
    end
    @(negedge clk);
    in_valid        = 1'b1;
    in_opcode       = op;
    in_now_ms       = now;
    in_packet_kind  = kind;
    in_source_id    = src;
    in_dest_id      = dst;
    in_prev_hop     = prev;
    in_hop_count    = hops;
    in_frame_length = flen;
    do @(posedge clk); while (in_stall);
    items_sent++;
  endtask

  // Drop valid and wait until every result is back and the block is quiet.
  task automatic wait_idle();
    @(negedge clk);
    in_valid = 1'b0;
    wait (pending == 0);
    repeat (ROUTE_ENTRIES + 8) @(negedge clk);
  endtask

  task automatic cfg_write(input cfg_idx_t idx, input logic [31:0] data);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    @(negedge clk);
    cfg_we    = 1'b0;
  endtask

  // Mostly a small address pool so routes get hit, refreshed and evicted.
  function automatic logic [7:0] pick_addr();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 8'd2 + 8'($urandom_range(0, 21));
    if (r < 70) return cur_node;
    if (r < 80) return ADDR_BCAST;
    if (r < 85) return ADDR_NONE;
    return 8'($urandom);
  endfunction

  task automatic random_item();
    int          r;
    logic [31:0] now;
    logic [7:0]  hops;
    logic [7:0]  flen;
    logic [2:0]  kind;
    now      = clock_ms;
    clock_ms = clock_ms + $urandom_range(0, step_ms);
    r        = $urandom_range(0, 99);
    if (r < 45) begin
      // well-formed header: passes both drop checks
      hops = 8'($urandom_range(0, cur_maxh - 1));
      flen = 8'($urandom_range(HEADER_BYTES, 255));
      kind = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(5, 7))
                                          : 3'($urandom_range(0, 4));
      send_item(OP_RX, now, kind, pick_addr(), pick_addr(), pick_addr(), hops, flen);
    end else if (r < 50) begin
      // broken header: short frame or at or over the hop limit
      if ($urandom_range(0, 1)) begin
        hops = 8'($urandom_range(0, cur_maxh - 1));
        flen = 8'($urandom_range(0, HEADER_BYTES - 1));
      end else begin
        hops = 8'($urandom_range(cur_maxh, 255));
        flen = 8'($urandom_range(HEADER_BYTES, 255));
      end
      send_item(OP_RX, now, 3'($urandom), pick_addr(), pick_addr(), pick_addr(), hops, flen);
    end else if (r < 72) begin
      send_item(OP_SEND, now, 3'($urandom), 8'($urandom), pick_addr(), 8'($urandom),
                8'($urandom), 8'($urandom));
    end else if (r < 88) begin
      send_item(OP_TICK, now, 3'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                8'($urandom), 8'($urandom));
    end else begin
      // noise: any opcode, any time, any field
      send_item(op_t'($urandom_range(0, 3)), $urandom_range(0, 1) ? now : $urandom,
                3'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                8'($urandom));
    end
  endtask

  // One register setting followed by a burst of random items. Upper bits
  // of the 8-bit registers carry junk the block must ignore.
  task automatic run_phase(input logic [7:0] node, input logic [7:0] maxh,
                           input logic [31:0] tmo, input logic [31:0] bcn,
                           input logic [31:0] start_ms, input logic [31:0] step,
                           input int idle, input bit with_hold);
    wait_idle();
    cfg_write(CFG_NODE_ID, {24'($urandom), node});
    cfg_write(CFG_MAX_HOPS, {24'($urandom), maxh});
    cfg_write(CFG_TIMEOUT, tmo);
    cfg_write(CFG_BEACON, bcn);
    settings_used++;
    cur_node = node;
    cur_maxh = maxh;
    clock_ms = start_ms;
    step_ms  = step;
    idle_pct = idle;
    for (int n = 0; n < PHASE_ITEMS; n++) begin
      if (with_hold && n == 30) hold_req = 1'b1;
      random_item();
    end
  endtask

  initial begin
    rst_n           = 1'b0;
    cfg_we          = 1'b0;
    cfg_index       = CFG_NODE_ID;
    cfg_data        = '0;
    in_valid        = 1'b0;
    in_opcode       = OP_NONE;
    in_now_ms       = '0;
    in_packet_kind  = KIND_DATA;
    in_source_id    = '0;
    in_dest_id      = '0;
    in_prev_hop     = '0;
    in_hop_count    = '0;
    in_frame_length = '0;
    idle_pct        = 19;
    hold_req        = 1'b0;
    cur_node        = 8'd1;
    cur_maxh        = 8'd8;
    clock_ms        = '0;
    step_ms         = 32'd100;
    items_sent      = 0;
    settings_used   = 1;
    repeat (12) @(negedge clk);
    rst_n = 1'b1;

    // directed items under the reset settings (node 1, hop limit 8)
    send_item(OP_SEND, 32'd100, KIND_DATA, 8'd0, ADDR_BCAST, 8'd0, 8'd0, 8'd0);
    send_item(OP_SEND, 32'd110, KIND_DATA, 8'd0, 8'd5, 8'd0, 8'd0, 8'd0);    // no route
    send_item(OP_RX, 32'd120, KIND_DATA, 8'd4, 8'd1, 8'd0, 8'd0, 8'd8);      // short frame
    send_item(OP_RX, 32'd130, KIND_DATA, 8'd4, 8'd1, 8'd0, 8'd7, 8'd9);      // empty payload
    send_item(OP_RX, 32'd140, KIND_DATA, 8'd4, 8'd1, 8'd0, 8'd8, 8'd60);     // hop limit
    send_item(OP_RX, 32'd150, KIND_RREP, 8'd10, ADDR_BCAST, 8'd20, 8'd3, 8'd40); // relayed
    send_item(OP_SEND, 32'd160, KIND_DATA, 8'd0, 8'd10, 8'd0, 8'd0, 8'd0);   // via 20
    send_item(OP_RX, 32'd170, KIND_BEACON, 8'd30, 8'd1, ADDR_BCAST, 8'd0, 8'd12);
    send_item(OP_SEND, 32'd180, KIND_DATA, 8'd0, 8'd30, 8'd0, 8'd0, 8'd0);   // direct
    send_item(OP_RX, 32'd190, KIND_RREQ, 8'd40, ADDR_BCAST, 8'd0, 8'd1, 8'd20);
    send_item(OP_RX, 32'd200, KIND_RREQ, 8'd40, 8'd1, 8'd0, 8'd1, 8'd20);
    send_item(OP_RX, 32'd210, KIND_RERR, 8'd41, 8'd1, 8'd0, 8'd2, 8'd255);
    send_item(OP_RX, 32'd220, 3'd7, 8'd42, ADDR_BCAST, 8'd0, 8'd0, 8'd9);    // unnamed kind
    send_item(OP_RX, 32'd230, KIND_DATA, 8'd43, 8'd2, 8'd0, 8'd0, 8'd50);    // not for us
    send_item(OP_TICK, 32'd240, KIND_DATA, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0);    // not due
    send_item(OP_TICK, 32'd30000, KIND_DATA, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0);  // due exactly
    send_item(OP_TICK, 32'd59999, KIND_DATA, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0);  // one short
    send_item(OP_TICK, 32'd200000, KIND_DATA, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0); // all stale
    send_item(OP_SEND, 32'd200010, KIND_DATA, 8'd0, 8'd10, 8'd0, 8'd0, 8'd0); // expired
    send_item(OP_NONE, 32'hFFFF_FFFF, 3'd7, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
    send_item(OP_RX, 32'hFFFF_FFFF, 3'd7, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
    send_item(OP_RX, 32'd0, KIND_DATA, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0);

    // lowest settings, time starting just before the wrap
    run_phase(8'd0, 8'd1, 32'd0, 32'd0, 32'hFFFF_F000, 32'd50, 19, 1'b0);
    // highest settings: nothing expires, table churns by age
    run_phase(8'd254, 8'd255, 32'hFFFF_FFFF, 32'hFFFF_FFFF, $urandom, 32'h4000_0000,
              19, 1'b0);
    // short timers, with the long output hold-off
    run_phase(8'd7, 8'd16, 32'd2000, 32'd500, 32'd0, 32'd200, 19, 1'b1);
    // reset values again, no idling on either side
    run_phase(8'd1, 8'd8, 32'd120000, 32'd30000, 32'd5000, 32'd20000, 0, 1'b0);
    repeat (3)
      run_phase(8'($urandom_range(0, 254)), 8'($urandom_range(1, 255)),
                $urandom_range(0, 5000), $urandom_range(0, 3000), $urandom, 32'd800,
                19, 1'b0);
    run_phase(8'($urandom_range(0, 254)), 8'($urandom_range(1, 255)), $urandom, $urandom,
              $urandom, $urandom, 19, 1'b0);

    wait_idle();
    $display("Covered %0d items across %0d register settings, with wraparound time,",
             items_sent, settings_used);
    $display("route eviction and expiry, beacons and a %0d-cycle output hold-off.",
             HOLD_CYCLES);
    if (fail_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

@@ files.f @@
src/mrte_pkg.sv
src/mrte_ram.sv
src/mrte_scan.sv
src/mesh_route_table_engine.sv
test/mrte_route_checker.sv
test/mesh_route_table_engine_tb.sv
